// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by iteration_palette_colorizer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ICP_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("icp assertion failed");

// next-cycle implication
`define ICP_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("icp assertion failed");

`endif

// ===== rtl/core/icp_pkg.sv =====
// ----------------------------------------------------------------------------
// icp_pkg
// Types and constants of the iteration palette colorizer.
// ----------------------------------------------------------------------------
package icp_pkg;

   localparam int ICP_PALETTE_DEPTH = 16;
   localparam int ICP_COUNT_WIDTH   = 16;
   localparam int ICP_CHANNELS      = 4;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [15:0] MAX_ITER_RESET    = 16'd255;
   localparam logic [4:0]  COLOR_COUNT_RESET = 5'd2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MAX_ITER    = 2'd0,
      CSR_COLOR_COUNT = 2'd1,
      CSR_INTERPOLATE = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_MAP   = 1'b1
   } op_type;

endpackage

// ===== rtl/core/icp_ram.sv =====
// ----------------------------------------------------------------------------
// icp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module icp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/iteration_palette_colorizer.sv =====
// ----------------------------------------------------------------------------
// iteration_palette_colorizer
// Maps escape-time iteration counts to 32-bit colors from a loadable
// palette, optionally blending neighboring entries per byte channel.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------
//  request  | req_operation, req_iteration_count,     | start & !busy
//           | req_palette_index, req_palette_word     |
//  response | rsp_pixel_color                         | rsp_valid, one cycle
//  csr      | csr_index, csr_wdata                    | csr_valid & csr_ready
//
//  One word per cycle while busy is low. The pipeline has one stage per
//  quotient bit of the palette index divide, one per bit of the 8-bit
//  blend divide, plus accept, multiply, RAM read and sum stages.
//  Synchronous reset clears valid bits; busy is a registered copy of reset,
//  so it is also high in the cycle after reset falls.
//  The pipeline never stalls; palette writes take effect in request order.
// ----------------------------------------------------------------------------
module iteration_palette_colorizer #(
   parameter int PALETTE_DEPTH = icp_pkg::ICP_PALETTE_DEPTH,
   parameter int COUNT_WIDTH   = icp_pkg::ICP_COUNT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_operation,
   input  logic [15:0]                         req_iteration_count,
   input  logic [3:0]                          req_palette_index,
   input  logic [31:0]                         req_palette_word,
   output logic                                rsp_valid,
   output logic [31:0]                         rsp_pixel_color,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [icp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [icp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   import icp_pkg::*;
   `include "assert_macros.svh"

   localparam int CW  = COUNT_WIDTH;
   localparam int IW  = $clog2(PALETTE_DEPTH);
   localparam int PW  = CW + IW;
   localparam int NW  = CW + 8;
   localparam int KCW = (IW + 1 > 5) ? IW + 1 : 5;
   localparam int AXW = (IW + 1 > 4) ? IW + 1 : 4;
   localparam int NCH = ICP_CHANNELS;
   localparam int BQ  = 8;
   localparam int LAT = IW + 13;

   // configuration
   logic [15:0] max_iter_ff;
   logic [4:0]  color_count_ff;
   logic        interpolate_ff;
   logic        busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
      if (reset) begin
         max_iter_ff    <= MAX_ITER_RESET;
         color_count_ff <= COLOR_COUNT_RESET;
         interpolate_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_ITER:    max_iter_ff    <= csr_wdata[15:0];
            CSR_COLOR_COUNT: color_count_ff <= csr_wdata[4:0];
            CSR_INTERPOLATE: interpolate_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = busy_ff;

   logic [47:0]    mx_ext;
   logic [CW-1:0]  mx_raw;
   logic [CW-1:0]  mx;
   logic [KCW-1:0] cc_ext;
   logic [KCW-1:0] k_w;
   logic [KCW-1:0] km1_w;
   logic [IW-1:0]  km1;

   always_comb begin
      mx_ext = {32'd0, max_iter_ff};
      mx_raw = mx_ext[CW-1:0];
      mx     = (mx_raw == '0) ? CW'(1) : mx_raw;
      cc_ext = KCW'(color_count_ff);
      if (cc_ext < KCW'(2)) begin
         k_w = KCW'(2);
      end else if (cc_ext > KCW'(PALETTE_DEPTH)) begin
         k_w = KCW'(PALETTE_DEPTH);
      end else begin
         k_w = cc_ext;
      end
      km1_w = k_w - KCW'(1);
      km1   = km1_w[IW-1:0];
   end

   // stage 0: accept and saturate
   logic          accept;
   logic [47:0]   cnt_ext;
   logic [CW-1:0] cnt;
   logic [CW-1:0] n_in;

   logic          v0_ff;
   logic          op0_ff;
   logic [CW-1:0] n0_ff;
   logic [3:0]    idx0_ff;
   logic [31:0]   word0_ff;

   assign accept  = start && !busy;
   assign cnt_ext = {32'd0, req_iteration_count};
   assign cnt     = cnt_ext[CW-1:0];
   assign n_in    = (cnt > mx) ? mx : cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= accept;
      end
      op0_ff   <= req_operation;
      n0_ff    <= n_in;
      idx0_ff  <= req_palette_index;
      word0_ff <= req_palette_word;
   end

   // index divide: entry 0 holds p = n*(k-1), one quotient bit per stage
   logic          dv_ff   [IW+1];
   logic          dop_ff  [IW+1];
   logic [PW-1:0] drem_ff [IW+1];
   logic [IW-1:0] dq_ff   [IW+1];
   logic [CW-1:0] dn_ff   [IW+1];
   logic [3:0]    didx_ff [IW+1];
   logic [31:0]   dword_ff[IW+1];

   logic [PW-1:0] drem_in [IW+1];
   logic [IW-1:0] dq_in   [IW+1];

   always_comb begin
      logic [PW-1:0] dsr;
      drem_in[0] = {{IW{1'b0}}, n0_ff} * {{CW{1'b0}}, km1};
      dq_in[0]   = '0;
      for (int s = 0; s < IW; s++) begin
         dsr          = PW'(mx) << (IW - 1 - s);
         drem_in[s+1] = drem_ff[s];
         dq_in[s+1]   = dq_ff[s];
         if (drem_ff[s] >= dsr) begin
            drem_in[s+1]          = drem_ff[s] - dsr;
            dq_in[s+1][IW-1-s]    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= IW; s++) begin
         if (reset) begin
            dv_ff[s] <= 1'b0;
         end else begin
            dv_ff[s] <= (s == 0) ? v0_ff : dv_ff[(s == 0) ? 0 : s - 1];
         end
         drem_ff[s] <= drem_in[s];
         dq_ff[s]   <= dq_in[s];
         if (s == 0) begin
            dop_ff[s]   <= op0_ff;
            dn_ff[s]    <= n0_ff;
            didx_ff[s]  <= idx0_ff;
            dword_ff[s] <= word0_ff;
         end else begin
            dop_ff[s]   <= dop_ff[s-1];
            dn_ff[s]    <= dn_ff[s-1];
            didx_ff[s]  <= didx_ff[s-1];
            dword_ff[s] <= dword_ff[s-1];
         end
      end
   end

   // palette access
   logic           quot_top;
   logic           special;
   logic [IW-1:0]  addr_a;
   logic [IW-1:0]  addr_b;
   logic [AXW-1:0] widx_ext;
   logic           wr_en;
   logic [31:0]    ram_a;
   logic [31:0]    ram_b;

   assign quot_top = dq_ff[IW] >= km1;
   assign special  = (dn_ff[IW] == mx) || quot_top;
   assign addr_a   = (interpolate_ff && special) ? km1 : dq_ff[IW];
   assign addr_b   = dq_ff[IW] + IW'(1);
   assign widx_ext = AXW'(didx_ff[IW]);
   assign wr_en    = dv_ff[IW] && (op_type'(dop_ff[IW]) == OP_WRITE) &&
                     (widx_ext < AXW'(PALETTE_DEPTH));

   icp_ram #(.WIDTH(32), .DEPTH(PALETTE_DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (widx_ext[IW-1:0]),
      .wr_data (dword_ff[IW]),
      .rd_addr (addr_a),
      .rd_data (ram_a)
   );

   icp_ram #(.WIDTH(32), .DEPTH(PALETTE_DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (widx_ext[IW-1:0]),
      .wr_data (dword_ff[IW]),
      .rd_addr (addr_b),
      .rd_data (ram_b)
   );

   logic          rv_ff;
   logic          rblend_ff;
   logic [CW-1:0] rr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= dv_ff[IW] && (op_type'(dop_ff[IW]) == OP_MAP);
      end
      rblend_ff <= interpolate_ff && !special;
      rr_ff     <= drem_ff[IW][CW-1:0];
   end

   // products a*(max-r) and b*r per channel
   logic                   m1v_ff;
   logic                   m1blend_ff;
   logic [31:0]            m1color_ff;
   logic [NCH-1:0][NW-1:0] pa_ff;
   logic [NCH-1:0][NW-1:0] pb_ff;
   logic [NCH-1:0][NW-1:0] pa_in;
   logic [NCH-1:0][NW-1:0] pb_in;
   logic [CW-1:0]          mxr;

   always_comb begin
      mxr = mx - rr_ff;
      for (int c = 0; c < NCH; c++) begin
         pa_in[c] = NW'(ram_a[8*c +: 8]) * NW'(mxr);
         pb_in[c] = NW'(ram_b[8*c +: 8]) * NW'(rr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1v_ff <= 1'b0;
      end else begin
         m1v_ff <= rv_ff;
      end
      m1blend_ff <= rblend_ff;
      m1color_ff <= ram_a;
      pa_ff      <= pa_in;
      pb_ff      <= pb_in;
   end

   // blend divide: entry 0 holds the sum, one quotient bit per stage
   logic                   bv_ff    [BQ+1];
   logic                   bblend_ff[BQ+1];
   logic [31:0]            bcolor_ff[BQ+1];
   logic [NCH-1:0][NW-1:0] brem_ff  [BQ+1];
   logic [NCH-1:0][BQ-1:0] bq_ff    [BQ+1];
   logic [NCH-1:0][NW-1:0] brem_in  [BQ+1];
   logic [NCH-1:0][BQ-1:0] bq_in    [BQ+1];

   always_comb begin
      logic [NW-1:0] bsr;
      for (int c = 0; c < NCH; c++) begin
         brem_in[0][c] = pa_ff[c] + pb_ff[c];
         bq_in[0][c]   = '0;
      end
      for (int s = 0; s < BQ; s++) begin
         bsr          = NW'(mx) << (BQ - 1 - s);
         brem_in[s+1] = brem_ff[s];
         bq_in[s+1]   = bq_ff[s];
         for (int c = 0; c < NCH; c++) begin
            if (brem_ff[s][c] >= bsr) begin
               brem_in[s+1][c]          = brem_ff[s][c] - bsr;
               bq_in[s+1][c][BQ-1-s]    = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= BQ; s++) begin
         if (reset) begin
            bv_ff[s] <= 1'b0;
         end else begin
            bv_ff[s] <= (s == 0) ? m1v_ff : bv_ff[(s == 0) ? 0 : s - 1];
         end
         brem_ff[s] <= brem_in[s];
         bq_ff[s]   <= bq_in[s];
         if (s == 0) begin
            bblend_ff[s] <= m1blend_ff;
            bcolor_ff[s] <= m1color_ff;
         end else begin
            bblend_ff[s] <= bblend_ff[s-1];
            bcolor_ff[s] <= bcolor_ff[s-1];
         end
      end
   end

   assign rsp_valid       = bv_ff[BQ];
   assign rsp_pixel_color = bblend_ff[BQ] ? 32'(bq_ff[BQ]) : bcolor_ff[BQ];

   `ICP_ASSERT_IMP(a_rsp_has_request, clock, reset, rsp_valid,
      $past(accept && (op_type'(req_operation) == OP_MAP), LAT))
   `ICP_ASSERT_IMP(a_busy_after_reset, clock, reset, busy, $past(reset))
   `ICP_ASSERT_IMP(a_index_in_range, clock, reset,
      dv_ff[IW] && (op_type'(dop_ff[IW]) == OP_MAP), dq_ff[IW] <= km1)
   `ICP_ASSERT_NXT(a_remainder_below_max, clock, reset,
      dv_ff[IW] && (op_type'(dop_ff[IW]) == OP_MAP), rr_ff < mx)

endmodule

// ===== bench/icp_checker.sv =====
// ----------------------------------------------------------------------------
// icp_checker
// Watches the request, response and csr channels of the colorizer. It keeps
// its own copy of the palette and registers, computes the color for each
// accepted map word and compares every response with the oldest expected one.
// ----------------------------------------------------------------------------
module icp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_operation,
   input  logic [15:0] req_iteration_count,
   input  logic [3:0]  req_palette_index,
   input  logic [31:0] req_palette_word,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_pixel_color,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [icp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [icp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int          fail_count,
   output int          pending_colors,
   output int          colors_checked
);
   import icp_pkg::*;

   logic [31:0] palette [ICP_PALETTE_DEPTH];
   logic [15:0] max_iter;
   logic [4:0]  color_count;
   logic        interpolate;
   logic [31:0] expected_colors [$];

   function automatic logic [31:0] mix_colors(logic [31:0] lo, logic [31:0] hi,
                                              longint unsigned r,
                                              longint unsigned mx);
      logic [31:0] res;
      longint unsigned a, b;
      res = '0;
      for (int c = 0; c < ICP_CHANNELS; c++) begin
         a = lo[8*c +: 8];
         b = hi[8*c +: 8];
         res[8*c +: 8] = 8'((a * (mx - r) + b * r) / mx);
      end
      return res;
   endfunction

   function automatic logic [31:0] color_of(logic [15:0] count);
      longint unsigned mx, n, k, p, i, r;
      mx = (max_iter == 0) ? 1 : max_iter;
      n = (count > mx) ? mx : count;
      k = color_count;
      if (k < 2) k = 2;
      if (k > ICP_PALETTE_DEPTH) k = ICP_PALETTE_DEPTH;
      p = n * (k - 1);
      i = p / mx;
      r = p % mx;
      if (i > k - 1) i = k - 1;
      if (!interpolate) return palette[i];
      if (n == mx || i + 1 >= k) return palette[k-1];
      return mix_colors(palette[i], palette[i+1], r, mx);
   endfunction

   assign pending_colors = expected_colors.size();

   always @(posedge clock) begin
      if (reset) begin
         max_iter    <= MAX_ITER_RESET;
         color_count <= COLOR_COUNT_RESET;
         interpolate <= 1'b0;
         expected_colors.delete();
         fail_count     <= 0;
         colors_checked <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_ITER:    max_iter    <= csr_wdata;
               CSR_COLOR_COUNT: color_count <= csr_wdata[4:0];
               CSR_INTERPOLATE: interpolate <= csr_wdata[0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_operation == OP_WRITE)
               palette[req_palette_index] <= req_palette_word;
            else
               expected_colors.push_back(color_of(req_iteration_count));
         end
         if (rsp_valid) begin
            colors_checked <= colors_checked + 1;
            if (expected_colors.size() == 0) begin
               $display("%0t: unexpected color word: got %08h", $time, rsp_pixel_color);
               fail_count <= fail_count + 1;
            end else begin
               if (expected_colors[0] !== rsp_pixel_color) begin
                  $display("%0t: pixel_color mismatch: expected %08h got %08h",
                           $time, expected_colors[0], rsp_pixel_color);
                  fail_count <= fail_count + 1;
               end
               void'(expected_colors.pop_front());
            end
         end
      end
   end
endmodule

// ===== bench/tb_iteration_palette_colorizer.sv =====
// ----------------------------------------------------------------------------
// tb_iteration_palette_colorizer
// Loads the palette, then runs map and palette-write words under a series of
// register settings, including the extremes, with bursty request traffic.
// ----------------------------------------------------------------------------
module tb_iteration_palette_colorizer;
   import icp_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_operation;
   logic [15:0] req_iteration_count;
   logic [3:0]  req_palette_index;
   logic [31:0] req_palette_word;
   logic        rsp_valid;
   logic [31:0] rsp_pixel_color;
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;
   int          fail_count, pending_colors, colors_checked;
   int          cycles = 0;
   int          words_sent = 0;
   int          burst_left = 0;
   logic [15:0] cur_max = MAX_ITER_RESET;

   iteration_palette_colorizer DUT (.*);

   icp_checker checker_inst (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic issue(op_type op, logic [15:0] cnt, logic [3:0] idx, logic [31:0] w);
      start               <= 1'b1;
      req_operation       <= op;
      req_iteration_count <= cnt;
      req_palette_index   <= idx;
      req_palette_word    <= w;
      do @(posedge clock); while (busy);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 8);
      end
   endtask

   task automatic settle;
      start <= 1'b0;
      @(posedge clock);
      while (pending_colors != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(logic [15:0] mx, logic [15:0] cc, logic [15:0] interp);
      settle();
      write_csr(CSR_MAX_ITER, mx);
      write_csr(CSR_COLOR_COUNT, cc);
      write_csr(CSR_INTERPOLATE, interp);
      cur_max = mx;
   endtask

   task automatic random_words(int n);
      logic [15:0] cnt;
      for (int j = 0; j < n; j++) begin
         if ($urandom_range(0, 4) == 0) begin
            issue(OP_WRITE, 16'($urandom), 4'($urandom), $urandom);
         end else begin
            case ($urandom_range(0, 5))
               0: cnt = cur_max;
               1: cnt = 16'($urandom);
               2: cnt = (cur_max == 0) ? 16'd0 : 16'($urandom_range(0, cur_max));
               3: cnt = 16'($urandom_range(0, 3));
               4: cnt = (cur_max == 0) ? 16'd1 : cur_max - 16'd1;
               default: cnt = (cur_max == 0) ? 16'd0 : 16'($urandom_range(0, cur_max));
            endcase
            issue(OP_MAP, cnt, 4'($urandom), $urandom);
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      start               <= 1'b0;
      req_operation       <= OP_WRITE;
      req_iteration_count <= '0;
      req_palette_index   <= '0;
      req_palette_word    <= '0;
      csr_valid           <= 1'b0;
      csr_index           <= CSR_MAX_ITER;
      csr_wdata           <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // load every entry first so no map can reach an unwritten one
      issue(OP_WRITE, 16'hFFFF, 4'd0, 32'h0000_0000);
      issue(OP_WRITE, 16'h0000, 4'd1, 32'hFFFF_FFFF);
      for (int e = 2; e < ICP_PALETTE_DEPTH; e++)
         issue(OP_WRITE, 16'($urandom), 4'(e), $urandom);
      issue(OP_MAP, 16'd0, 4'hF, 32'hFFFF_FFFF);
      issue(OP_MAP, 16'd255, 4'd0, 32'd0);
      issue(OP_MAP, 16'hFFFF, 4'd0, 32'd0);
      issue(OP_MAP, 16'd127, 4'd0, 32'd0);
      issue(OP_MAP, 16'd1, 4'd0, 32'd0);
      configure(16'd255, 16'd2, 16'd1);
      issue(OP_MAP, 16'd128, 4'd0, 32'd0);
      issue(OP_MAP, 16'd254, 4'd0, 32'd0);
      issue(OP_MAP, 16'd255, 4'd0, 32'd0);
      issue(OP_MAP, 16'd300, 4'd0, 32'd0);

      random_words(150);
      configure(16'd1, 16'd16, 16'd1);
      random_words(150);
      configure(16'hFFFF, 16'd16, 16'd1);
      random_words(150);
      configure(16'hFFFF, 16'd16, 16'd0);
      random_words(150);
      configure(16'd0, 16'd0, 16'd1);
      random_words(150);
      configure(16'd15, 16'd31, 16'hFFFE);
      random_words(150);
      configure(16'd1000, 16'd17, 16'd1);
      random_words(150);
      for (int ph = 0; ph < 4; ph++) begin
         configure(16'($urandom_range(1, 65535)), 16'($urandom_range(2, 16)),
                   16'($urandom));
         random_words(125);
      end
      settle();

      $display("sent %0d request words, checked %0d color words across 12 settings",
               words_sent, colors_checked);
      $display("settings covered max_iter 0/1/max, color_count 0/2/16/17/31, both modes");
      if (fail_count == 0 && pending_colors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/icp_pkg.sv
rtl/core/icp_ram.sv
rtl/core/iteration_palette_colorizer.sv
bench/icp_checker.sv
bench/tb_iteration_palette_colorizer.sv
